// File: hdl/qcig_pkg.sv
// Package for the quality context index generator.
// Holds the register index codes, the field widths and the root bucket table.
// No dependencies.
package qcig_pkg;

    localparam int CfgIdxW  = 4;
    localparam int CfgDataW = 16;
    localparam int CtxW     = 16;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_QUAL_CTX_BITS   = 4'd0,
        CFG_QUAL_CTX_SHIFT  = 4'd1,
        CFG_POS_CTX_BITS    = 4'd2,
        CFG_POS_CTX_SHIFT   = 4'd3,
        CFG_DELTA_CTX_BITS  = 4'd4,
        CFG_DELTA_CTX_SHIFT = 4'd5,
        CFG_FIELD_OFFSETS   = 4'd6,
        CFG_STRAND_ENABLE   = 4'd7
    } cfg_index_t;

    localparam logic [3:0]  QualCtxBitsRst   = 4'd10;
    localparam logic [3:0]  QualCtxShiftRst  = 4'd5;
    localparam logic [3:0]  PosCtxBitsRst    = 4'd4;
    localparam logic [3:0]  PosCtxShiftRst   = 4'd0;
    localparam logic [3:0]  DeltaCtxBitsRst  = 4'd2;
    localparam logic [3:0]  DeltaCtxShiftRst = 4'd1;
    localparam logic [15:0] FieldOffsetsRst  = 16'h09AE;

    localparam logic [7:0]  ChangeCountMax   = 8'd255;
    localparam logic [5:0]  RootIndexMax     = 6'd63;

    // Mask of the low 'bits' bits; a width of zero gives an empty mask.
    function automatic logic [CtxW-1:0] low_mask(input logic [3:0] bits);
        return (CtxW'(1) << bits) - CtxW'(1);
    endfunction

    // Square-root-like bucket of the scaled change count.
    function automatic logic [2:0] root_bucket(input logic [5:0] idx);
        logic [2:0] b;
        if (idx == 6'd0)
            b = 3'd0;
        else if (idx < 6'd4)
            b = 3'd1;
        else if (idx < 6'd9)
            b = 3'd2;
        else if (idx < 6'd16)
            b = 3'd3;
        else if (idx < 6'd25)
            b = 3'd4;
        else if (idx < 6'd36)
            b = 3'd5;
        else if (idx < 6'd49)
            b = 3'd6;
        else
            b = 3'd7;
        return b;
    endfunction

endpackage

// File: hdl/qcig_if.sv
// Channel interfaces of the quality context index generator.
// Depends on qcig_pkg for widths.
interface qcig_item_if;
    logic        valid;
    logic        ready;
    logic        read_start;
    logic [31:0] read_length;
    logic [7:0]  quality;
    logic [7:0]  symbol;
    logic        strand;

    modport source (output valid, read_start, read_length, quality, symbol, strand,
                    input ready);
    modport sink   (input valid, read_start, read_length, quality, symbol, strand,
                    output ready);
endinterface

interface qcig_result_if;
    logic                       valid;
    logic                       ready;
    logic [qcig_pkg::CtxW-1:0]  context_index;

    modport source (output valid, context_index, input ready);
    modport sink   (input valid, context_index, output ready);
endinterface

interface qcig_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [qcig_pkg::CfgIdxW-1:0]  index;
    logic [qcig_pkg::CfgDataW-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/quality_context_index_generator_top.sv
// Top level of the quality context index generator.
// Depends on qcig_pkg and the channel interfaces in qcig_if.sv.
//
//  channel   role    payload
//  -------   -----   ---------------------------------------------------
//  items     sink    read_start, read_length, quality, symbol, strand
//  results   source  context_index
//  cfg       sink    index, data (register write, always ready)
//
// One item is accepted per cycle unless the result is stalled; its result
// appears in the output register on the next cycle. The combinational context
// update between the state registers sets that rate. A new item is taken
// whenever the output register is empty or being drained. Reset clears all
// state but the output context, loads the register defaults; no clearing pass.
module quality_context_index_generator_top #(
    parameter int POSITION_LIMIT = 1024
) (
    input  logic            clk,
    input  logic            rst_n,
    qcig_item_if.sink       items,
    qcig_result_if.source   results,
    qcig_cfg_if.sink        cfg
);
    import qcig_pkg::*;

    localparam int PosW = $clog2(POSITION_LIMIT);
    localparam logic [PosW-1:0] PosMax = PosW'(POSITION_LIMIT - 1);

    logic [3:0]  qual_ctx_bits_reg, qual_ctx_shift_reg;
    logic [3:0]  pos_ctx_bits_reg, pos_ctx_shift_reg;
    logic [3:0]  delta_ctx_bits_reg, delta_ctx_shift_reg;
    logic [15:0] field_offsets_reg;
    logic        strand_enable_reg;

    logic [15:0] history_reg, history_next;
    logic [7:0]  change_count_reg, change_count_next;
    logic [7:0]  previous_quality_reg;
    logic [31:0] remaining_reg, remaining_next;
    logic [15:0] pending_context_reg, pending_context_next;

    logic             out_valid_reg;
    logic [CtxW-1:0]  out_context_reg;

    logic        accept;
    logic [15:0] hist_eff;
    logic [7:0]  change_eff, prev_eff;
    logic [31:0] rem_eff;
    logic [15:0] pending_eff;
    logic [PosW-1:0] pos_clamped;
    logic [15:0] pbucket_raw, pbucket, pmask;
    logic [7:0]  didx_raw;
    logic [5:0]  didx;
    logic [15:0] dbucket_raw, dbucket, dmask;
    logic [15:0] part_hist, part_pos, part_strand, part_delta;

    assign cfg.ready     = 1'b1;
    assign items.ready   = !out_valid_reg || results.ready;
    assign accept        = items.valid && items.ready;
    assign results.valid = out_valid_reg;
    assign results.context_index = out_context_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qual_ctx_bits_reg   <= QualCtxBitsRst;
            qual_ctx_shift_reg  <= QualCtxShiftRst;
            pos_ctx_bits_reg    <= PosCtxBitsRst;
            pos_ctx_shift_reg   <= PosCtxShiftRst;
            delta_ctx_bits_reg  <= DeltaCtxBitsRst;
            delta_ctx_shift_reg <= DeltaCtxShiftRst;
            field_offsets_reg   <= FieldOffsetsRst;
            strand_enable_reg   <= 1'b0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_QUAL_CTX_BITS:   qual_ctx_bits_reg   <= cfg.data[3:0];
                CFG_QUAL_CTX_SHIFT:  qual_ctx_shift_reg  <= cfg.data[3:0];
                CFG_POS_CTX_BITS:    pos_ctx_bits_reg    <= cfg.data[3:0];
                CFG_POS_CTX_SHIFT:   pos_ctx_shift_reg   <= cfg.data[3:0];
                CFG_DELTA_CTX_BITS:  delta_ctx_bits_reg  <= cfg.data[3:0];
                CFG_DELTA_CTX_SHIFT: delta_ctx_shift_reg <= cfg.data[3:0];
                CFG_FIELD_OFFSETS:   field_offsets_reg   <= cfg.data;
                CFG_STRAND_ENABLE:   strand_enable_reg   <= cfg.data[0];
                default: ;
            endcase
        end
    end

    // A read start clears the history and loads the new length before the
    // item is folded in, so its own result is context zero.
    always_comb
    begin
        hist_eff    = items.read_start ? 16'd0 : history_reg;
        change_eff  = items.read_start ? 8'd0 : change_count_reg;
        prev_eff    = items.read_start ? 8'd0 : previous_quality_reg;
        rem_eff     = items.read_start ? items.read_length : remaining_reg;
        pending_eff = items.read_start ? 16'd0 : pending_context_reg;

        history_next = (hist_eff << qual_ctx_shift_reg) + {8'd0, items.symbol};
        part_hist    = (history_next & low_mask(qual_ctx_bits_reg))
                       << field_offsets_reg[15:12];

        pos_clamped = (rem_eff < 32'(PosMax)) ? rem_eff[PosW-1:0] : PosMax;
        pbucket_raw = 16'(pos_clamped) >> pos_ctx_shift_reg;
        pmask       = low_mask(pos_ctx_bits_reg);
        pbucket     = (pbucket_raw > pmask) ? pmask : pbucket_raw;
        part_pos    = pbucket << field_offsets_reg[7:4];

        part_strand = (strand_enable_reg && items.strand)
                      ? (16'd1 << field_offsets_reg[11:8]) : 16'd0;

        didx_raw    = change_eff >> delta_ctx_shift_reg;
        didx        = (didx_raw > 8'(RootIndexMax)) ? RootIndexMax : didx_raw[5:0];
        dbucket_raw = {13'd0, root_bucket(didx)};
        dmask       = low_mask(delta_ctx_bits_reg);
        dbucket     = (dbucket_raw > dmask) ? dmask : dbucket_raw;
        part_delta  = dbucket << field_offsets_reg[3:0];

        pending_context_next = part_hist + part_pos + part_strand + part_delta;

        change_count_next = (items.quality != prev_eff && change_eff != ChangeCountMax)
                            ? change_eff + 8'd1 : change_eff;
        remaining_next    = (rem_eff != 32'd0) ? rem_eff - 32'd1 : 32'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            history_reg          <= '0;
            change_count_reg     <= '0;
            previous_quality_reg <= '0;
            remaining_reg        <= '0;
            pending_context_reg  <= '0;
        end
        else if (accept)
        begin
            history_reg          <= history_next;
            change_count_reg     <= change_count_next;
            previous_quality_reg <= items.quality;
            remaining_reg        <= remaining_next;
            pending_context_reg  <= pending_context_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (results.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_context_reg <= pending_eff;
    end

    // The first item of a read is always answered with context zero.
    a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
        accept && items.read_start |=> out_context_reg == 16'd0)
        else $error("read start did not give context zero");

    // A waiting result blocks new items.
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !results.ready |-> !items.ready)
        else $error("item accepted while result stalled");

    // Within a read the change count never falls.
    a_change_mono: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !items.read_start |=> change_count_reg >= $past(change_count_reg))
        else $error("change count decreased within a read");

    // Within a read the remaining count steps down by one until it reaches zero.
    a_remaining_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !items.read_start && remaining_reg != 32'd0
        |=> remaining_reg == $past(remaining_reg) - 32'd1)
        else $error("remaining count did not step down");

    // The stored context only moves when an item is transferred.
    a_pending_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(pending_context_reg))
        else $error("pending context changed without a transfer");

endmodule

// File: tb/quality_context_index_generator_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the quality context index generator top level.
// Depends on qcig_pkg, the channel interfaces in qcig_if.sv and the block itself.
module quality_context_index_generator_top_test;

    import qcig_pkg::*;

    localparam int PositionLimit = 1024;
    localparam int WatchdogLimit = 2000;

    typedef struct {
        logic        read_start;
        logic [31:0] read_length;
        logic [7:0]  quality;
        logic [7:0]  symbol;
        logic        strand;
    } quality_item_t;

    logic clk;
    logic rst_n;

    qcig_item_if   items_ch ();
    qcig_result_if results_ch ();
    qcig_cfg_if    cfg_ch ();

    quality_context_index_generator_top #(
        .POSITION_LIMIT (PositionLimit)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_ch),
        .results (results_ch),
        .cfg     (cfg_ch)
    );

    // Register copies, loaded with the reset values.
    logic [3:0]  qual_bits     = QualCtxBitsRst;
    logic [3:0]  qual_shift    = QualCtxShiftRst;
    logic [3:0]  pos_bits      = PosCtxBitsRst;
    logic [3:0]  pos_shift     = PosCtxShiftRst;
    logic [3:0]  delta_bits    = DeltaCtxBitsRst;
    logic [3:0]  delta_shift   = DeltaCtxShiftRst;
    logic [15:0] offsets_copy  = FieldOffsetsRst;
    logic        strand_on     = 1'b0;

    // Context state of the prediction.
    logic [15:0] hist_reg        = '0;
    logic [7:0]  changes_seen    = '0;
    logic [7:0]  last_quality    = '0;
    logic [31:0] remaining_count = '0;
    logic [15:0] next_context    = '0;

    quality_item_t pending_items[$];
    logic [15:0]   expected_contexts[$];
    int            items_queued   = 0;
    int            items_taken    = 0;
    int            mismatch_count = 0;
    int            quiet_cycles   = 0;
    int            send_idle_pct  = 0;
    int            stall_pct      = 0;

    // State of the read generator.
    int          gen_left    = 0;
    int          gen_reads   = 0;
    int          gen_mode    = 0;
    logic        gen_strand  = 1'b0;
    logic [7:0]  gen_quality = '0;

    function automatic logic [15:0] keep_mask(input logic [3:0] n);
        return ~(16'hFFFF << n);
    endfunction

    // Integer square root of the scaled change count.
    function automatic logic [2:0] root_step(input logic [5:0] v);
        logic [2:0] r;
        r = 3'd0;
        for (int k = 1; k < 8; k++)
            if (k * k <= int'(v))
                r = 3'(k);
        return r;
    endfunction

    // Returns the context under which this item's symbol is coded and moves
    // the state on to the context of the following item.
    function automatic logic [15:0] step_context(input quality_item_t x);
        logic [15:0] answer;
        logic [31:0] hist_wide;
        logic [31:0] ctx;
        logic [31:0] position;
        logic [31:0] pos_bucket;
        logic [7:0]  delta_idx;
        logic [15:0] delta_bucket;
        if (x.read_start)
        begin
            remaining_count = x.read_length;
            hist_reg        = '0;
            changes_seen    = '0;
            last_quality    = '0;
            next_context    = '0;
        end
        answer = next_context;

        hist_wide = ({16'd0, hist_reg} << qual_shift) + {24'd0, x.symbol};
        hist_reg  = hist_wide[15:0];
        ctx = {16'd0, hist_reg & keep_mask(qual_bits)} << offsets_copy[15:12];

        position = (remaining_count < 32'(PositionLimit - 1)) ?
                   remaining_count : 32'(PositionLimit - 1);
        pos_bucket = position >> pos_shift;
        if (pos_bucket > {16'd0, keep_mask(pos_bits)})
            pos_bucket = {16'd0, keep_mask(pos_bits)};
        ctx = ctx + (pos_bucket << offsets_copy[7:4]);

        if (strand_on && x.strand)
            ctx = ctx + (32'd1 << offsets_copy[11:8]);

        delta_idx = changes_seen >> delta_shift;
        if (delta_idx > 8'(RootIndexMax))
            delta_idx = 8'(RootIndexMax);
        delta_bucket = {13'd0, root_step(delta_idx[5:0])};
        if (delta_bucket > keep_mask(delta_bits))
            delta_bucket = keep_mask(delta_bits);
        ctx = ctx + ({16'd0, delta_bucket} << offsets_copy[3:0]);

        next_context = ctx[15:0];

        if (x.quality != last_quality && changes_seen != ChangeCountMax)
            changes_seen = changes_seen + 8'd1;
        last_quality = x.quality;
        if (remaining_count != 32'd0)
            remaining_count = remaining_count - 32'd1;
        return answer;
    endfunction

    // Next item of a stream of reads. Every eighth read is long with a change
    // of quality on every item, so that the change count saturates.
    function automatic quality_item_t random_item();
        quality_item_t x;
        int span;
        if (gen_mode != 2 && $urandom_range(99) < 3)
            gen_left = 0;
        if (gen_left == 0)
        begin
            gen_reads++;
            span = (gen_reads % 8 == 0) ? $urandom_range(330, 270) : $urandom_range(40, 1);
            gen_left   = span;
            gen_mode   = (span > 40) ? 2 : $urandom_range(2);
            gen_strand = 1'($urandom_range(1));
            x.read_start = 1'b1;
            case ($urandom_range(9))
                0:       x.read_length = $urandom();
                1:       x.read_length = 32'd0;
                2, 3:    x.read_length = $urandom_range(span - 1, 0);
                4:       x.read_length = $urandom_range(1100, 1000);
                default: x.read_length = 32'(span);
            endcase
        end
        else
        begin
            x.read_start  = 1'b0;
            x.read_length = $urandom();
        end
        gen_left--;
        case (gen_mode)
            0:       x.quality = ($urandom_range(9) == 0) ? 8'($urandom()) : gen_quality;
            1:       x.quality = 8'($urandom());
            default: x.quality = gen_quality + 8'($urandom_range(255, 1));
        endcase
        gen_quality = x.quality;
        x.symbol = ($urandom_range(1) == 1) ? 8'($urandom_range(63)) : 8'($urandom());
        x.strand = ($urandom_range(19) == 0) ? ~gen_strand : gen_strand;
        return x;
    endfunction

    task automatic queue_item(input quality_item_t x);
        pending_items.push_back(x);
        items_queued++;
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        mismatch_count++;
        if (mismatch_count <= 50)
            $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
    endtask

    task automatic write_register(input cfg_index_t idx, input logic [15:0] value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_QUAL_CTX_BITS:   qual_bits    = value[3:0];
            CFG_QUAL_CTX_SHIFT:  qual_shift   = value[3:0];
            CFG_POS_CTX_BITS:    pos_bits     = value[3:0];
            CFG_POS_CTX_SHIFT:   pos_shift    = value[3:0];
            CFG_DELTA_CTX_BITS:  delta_bits   = value[3:0];
            CFG_DELTA_CTX_SHIFT: delta_shift  = value[3:0];
            CFG_FIELD_OFFSETS:   offsets_copy = value;
            CFG_STRAND_ENABLE:   strand_on    = value[0];
            default: ;
        endcase
    endtask

    // Holds the sender back until every context has come out and the block
    // has settled, so that registers are only written while it is idle.
    task automatic wait_until_drained();
        while (items_taken != items_queued || expected_contexts.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    always #10 clk = ~clk;

    // Item driver; predicts the context of each item at its transfer.
    always @(posedge clk)
    begin
        quality_item_t seen;
        quality_item_t next_item;
        if (!rst_n)
            items_ch.valid <= 1'b0;
        else
        begin
            if (items_ch.valid && items_ch.ready)
            begin
                seen.read_start  = items_ch.read_start;
                seen.read_length = items_ch.read_length;
                seen.quality     = items_ch.quality;
                seen.symbol      = items_ch.symbol;
                seen.strand      = items_ch.strand;
                expected_contexts.push_back(step_context(seen));
                items_taken++;
            end
            if (!items_ch.valid || items_ch.ready)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_item = pending_items.pop_front();
                    items_ch.valid       <= 1'b1;
                    items_ch.read_start  <= next_item.read_start;
                    items_ch.read_length <= next_item.read_length;
                    items_ch.quality     <= next_item.quality;
                    items_ch.symbol      <= next_item.symbol;
                    items_ch.strand      <= next_item.strand;
                end
                else
                    items_ch.valid <= 1'b0;
            end
        end
    end

    // Result monitor.
    always @(posedge clk)
    begin
        logic [15:0] want;
        if (!rst_n)
            results_ch.ready <= 1'b0;
        else
        begin
            if (results_ch.valid && results_ch.ready)
            begin
                if (expected_contexts.size() == 0)
                    report_mismatch("context with nothing expected",
                                    results_ch.context_index, 16'h0000);
                else
                begin
                    want = expected_contexts.pop_front();
                    if (results_ch.context_index !== want)
                        report_mismatch("context_index", results_ch.context_index, want);
                end
            end
            results_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (items_ch.valid && items_ch.ready) ||
            (results_ch.valid && results_ch.ready) || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == WatchdogLimit)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        logic [15:0] setting [8];
        clk                  = 1'b0;
        rst_n                = 1'b0;
        items_ch.valid       = 1'b0;
        items_ch.read_start  = 1'b0;
        items_ch.read_length = '0;
        items_ch.quality     = '0;
        items_ch.symbol      = '0;
        items_ch.strand      = 1'b0;
        results_ch.ready     = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = '0;
        cfg_ch.data          = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < 8; phase++)
        begin
            if (phase != 0)
            begin
                wait_until_drained();
                case (phase)
                    1: setting = '{16'hFFF0, 16'hFFF0, 16'hFFF0, 16'hFFF0,
                                   16'hFFF0, 16'hFFF0, 16'h0000, 16'h0001};
                    2: setting = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                   16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
                    3: setting = '{16'h000F, 16'h0001, 16'h000A, 16'h0000,
                                   16'h0003, 16'h0000, 16'h0F4C, 16'h0001};
                    default:
                        for (int r = 0; r < 8; r++)
                            setting[r] = 16'($urandom());
                endcase
                for (int r = 0; r < 8; r++)
                    write_register(cfg_index_t'(r), setting[r]);
            end

            case (phase % 4)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 65; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 65; end
                default: begin send_idle_pct = 22; stall_pct = 22; end
            endcase

            if (phase == 0)
            begin
                // Items before any read start, with the remaining count at zero.
                queue_item(quality_item_t'{1'b0, 32'd0, 8'd0, 8'd0, 1'b0});
                queue_item(quality_item_t'{1'b0, 32'hFFFF_FFFF, 8'd255, 8'd255, 1'b1});
                // Zero length read, then the longest one.
                queue_item(quality_item_t'{1'b1, 32'd0, 8'd7, 8'd3, 1'b0});
                queue_item(quality_item_t'{1'b0, 32'd0, 8'd7, 8'd4, 1'b0});
                queue_item(quality_item_t'{1'b1, 32'hFFFF_FFFF, 8'd255, 8'd255, 1'b1});
                queue_item(quality_item_t'{1'b0, 32'd0, 8'd0, 8'd0, 1'b1});
                // Lengths around the position clamp.
                queue_item(quality_item_t'{1'b1, 32'd1024, 8'd1, 8'd1, 1'b0});
                queue_item(quality_item_t'{1'b0, 32'd0, 8'd2, 8'd2, 1'b0});
                queue_item(quality_item_t'{1'b1, 32'd1023, 8'd3, 8'd5, 1'b1});
                queue_item(quality_item_t'{1'b0, 32'd0, 8'd3, 8'd6, 1'b1});
                queue_item(quality_item_t'{1'b1, 32'd1022, 8'd4, 8'd7, 1'b0});
                queue_item(quality_item_t'{1'b0, 32'd0, 8'd5, 8'd8, 1'b0});
                // A short read that runs past its stated length.
                queue_item(quality_item_t'{1'b1, 32'd2, 8'd9, 8'd17, 1'b1});
                queue_item(quality_item_t'{1'b0, 32'd0, 8'd10, 8'd18, 1'b1});
                queue_item(quality_item_t'{1'b0, 32'd0, 8'd9, 8'd19, 1'b1});
                queue_item(quality_item_t'{1'b0, 32'd0, 8'd10, 8'd20, 1'b1});
                queue_item(quality_item_t'{1'b0, 32'd0, 8'd9, 8'd21, 1'b1});
                queue_item(quality_item_t'{1'b1, 32'h8000_0000, 8'd128, 8'd128, 1'b0});
                queue_item(quality_item_t'{1'b0, 32'd0, 8'd0, 8'd127, 1'b0});
                queue_item(quality_item_t'{1'b0, 32'd0, 8'd255, 8'd64, 1'b0});
                queue_item(quality_item_t'{1'b0, 32'd0, 8'd0, 8'd32, 1'b0});
            end

            repeat ((phase == 0) ? 100 : 120)
                queue_item(random_item());
        end

        wait_until_drained();
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: quality_context_index_generator_top.f
hdl/qcig_pkg.sv
hdl/qcig_if.sv
hdl/quality_context_index_generator_top.sv
tb/quality_context_index_generator_top_test.sv
